// ===== sv/msd_pkg.sv =====
// Shared types and constants for the motion segment detector.
// No dependencies; imported by msd_sq_acc, msd_seg and the top level.
package msd_pkg;

    localparam int VEL_W    = 16;
    localparam int NORM_W   = 32;
    localparam int WIN_W    = 7;
    localparam int HOLD_W   = 16;
    localparam int MINSEG_W = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEG = 3'd3;

    // control beat from the sequencer to the flag/segment tracker
    typedef struct packed {
        logic step;   // produce a flag and advance the tracker
        logic raw;    // window max above threshold
        logic last;   // final sample of the trajectory
        logic clear;  // return tracker to start-of-stream
    } msd_ctl_t;

endpackage

// ===== sv/msd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module msd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/msd_sq_acc.sv =====
// Iterative squared-norm unit: one 16x16 multiplier, three squares summed.
// Depends on msd_pkg.
module msd_sq_acc (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [msd_pkg::VEL_W-1:0]    vel_x,
    input  logic signed [msd_pkg::VEL_W-1:0]    vel_y,
    input  logic signed [msd_pkg::VEL_W-1:0]    vel_z,
    output logic                                done,
    output logic [msd_pkg::NORM_W-1:0]          norm_sq
);
    import msd_pkg::*;

    logic signed [VEL_W-1:0] x_reg, y_reg, z_reg;
    logic signed [VEL_W-1:0] op;
    logic signed [NORM_W-1:0] sq;
    logic [NORM_W-1:0] prod_reg, acc_reg;
    logic [1:0] step_reg;
    logic busy_reg, done_reg;

    always_comb begin
        unique case (step_reg)
            2'd0:    op = x_reg;
            2'd1:    op = y_reg;
            2'd2:    op = z_reg;
            default: op = '0;
        endcase
    end

    assign sq = NORM_W'(op) * NORM_W'(op);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                acc_reg  <= '0;
                x_reg    <= vel_x;
                y_reg    <= vel_y;
                z_reg    <= vel_z;
            end else if (busy_reg) begin
                prod_reg <= sq;
                if (step_reg != 2'd0) begin
                    acc_reg <= acc_reg + prod_reg;
                end
                if (step_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 2'd1;
            end
        end
    end

    assign done    = done_reg;
    assign norm_sq = acc_reg;

endmodule

// ===== sv/msd_seg.sv =====
// Moving-flag hold counter and segment run tracker, one step per flag.
// Depends on msd_pkg (msd_ctl_t, field widths).
module msd_seg #(
    parameter int INDEX_WIDTH = 20
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  msd_pkg::msd_ctl_t             ctl,
    input  logic [msd_pkg::HOLD_W-1:0]    hold_length,
    input  logic [msd_pkg::MINSEG_W-1:0]  min_seg_len,
    output logic [INDEX_WIDTH-1:0]        sample_index,
    output logic                          moving,
    output logic                          seg_valid,
    output logic [INDEX_WIDTH-1:0]        seg_start,
    output logic [INDEX_WIDTH-1:0]        seg_length
);
    import msd_pkg::*;

    localparam logic [INDEX_WIDTH-1:0] IDX_MAX = {INDEX_WIDTH{1'b1}};

    logic [INDEX_WIDTH-1:0] flag_index_reg, run_start_reg, run_length_reg;
    logic [HOLD_W-1:0]      hold_count_reg;
    logic                   in_run_reg;

    logic [INDEX_WIDTH-1:0] len_eff, start_eff;
    logic                   in_run_eff, close;

    assign moving     = ctl.raw || (hold_count_reg != '0);
    assign in_run_eff = in_run_reg || moving;
    assign start_eff  = in_run_reg ? run_start_reg : flag_index_reg;

    always_comb begin
        if (!moving) begin
            len_eff = run_length_reg;
        end else if (!in_run_reg) begin
            len_eff = INDEX_WIDTH'(1);
        end else if (run_length_reg == IDX_MAX) begin
            len_eff = IDX_MAX;
        end else begin
            len_eff = run_length_reg + INDEX_WIDTH'(1);
        end
    end

    assign close        = in_run_eff && (!moving || ctl.last);
    assign seg_valid    = close && (64'(len_eff) > 64'(min_seg_len));
    assign seg_start    = seg_valid ? start_eff : '0;
    assign seg_length   = seg_valid ? len_eff : '0;
    assign sample_index = flag_index_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_index_reg <= '0;
            hold_count_reg <= '0;
            in_run_reg     <= 1'b0;
            run_start_reg  <= '0;
            run_length_reg <= '0;
        end else if (ctl.clear || (ctl.step && ctl.last)) begin
            flag_index_reg <= '0;
            hold_count_reg <= '0;
            in_run_reg     <= 1'b0;
            run_start_reg  <= '0;
            run_length_reg <= '0;
        end else if (ctl.step) begin
            if (flag_index_reg != IDX_MAX) begin
                flag_index_reg <= flag_index_reg + INDEX_WIDTH'(1);
            end
            if (ctl.raw) begin
                hold_count_reg <= hold_length;
            end else if (hold_count_reg != '0) begin
                hold_count_reg <= hold_count_reg - HOLD_W'(1);
            end
            if (close) begin
                in_run_reg     <= 1'b0;
                run_start_reg  <= '0;
                run_length_reg <= '0;
            end else begin
                in_run_reg     <= in_run_eff;
                run_start_reg  <= in_run_eff ? start_eff : '0;
                run_length_reg <= len_eff;
            end
        end
    end

endmodule

// ===== sv/motion_segment_detector_unit.sv =====
// An accepted beat passes through S_NORM (squared norm), S_WRITE (ring write), S_SCAN
// (one ring read per window entry), S_DRAIN and S_FLAG (flag step) to its result beat.
// A new beat is taken only in S_IDLE, once the result of the last one has been loaded.
// A beat that does not fill the window ends after the ring write.
// Reset (aresetn, synchronous, active low) clears control state, configuration and counters;
// the norm ring is not cleared.
module motion_segment_detector_unit #(
    parameter int MAX_WINDOW  = 64,
    parameter int INDEX_WIDTH = 20
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [msd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [msd_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [msd_pkg::VEL_W-1:0]     s_vel_x,
    input  logic signed [msd_pkg::VEL_W-1:0]     s_vel_y,
    input  logic signed [msd_pkg::VEL_W-1:0]     s_vel_z,
    input  logic                                 s_last,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [INDEX_WIDTH-1:0]               m_sample_index,
    output logic                                 m_moving,
    output logic                                 m_segment_valid,
    output logic [INDEX_WIDTH-1:0]               m_segment_start,
    output logic [INDEX_WIDTH-1:0]               m_segment_length,
    output logic                                 m_final_res
);
    import msd_pkg::*;

    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_WINDOW - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_WINDOW);

    typedef enum logic [2:0] {
        S_IDLE, S_NORM, S_WRITE, S_SCAN, S_DRAIN, S_FLAG
    } state_t;

    state_t state_reg;

    logic [NORM_W-1:0]   thresh_reg;
    logic [WIN_W-1:0]    window_reg;
    logic [HOLD_W-1:0]   hold_len_reg;
    logic [MINSEG_W-1:0] min_seg_reg;

    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg, fill_next, issue_cnt_reg, win_eff;
    logic             last_reg, scan_vld_reg;
    logic [NORM_W-1:0] max_reg;

    logic              accept, sq_done, out_load;
    logic [NORM_W-1:0] norm_sq, ram_q;

    msd_ctl_t               ctl;
    logic [INDEX_WIDTH-1:0] seg_idx, seg_start, seg_len;
    logic                   seg_moving, seg_valid;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        if (window_reg == '0) begin
            win_eff = CNT_W'(1);
        end else if (32'(window_reg) > 32'(MAX_WINDOW)) begin
            win_eff = CNT_FULL;
        end else begin
            win_eff = CNT_W'(window_reg);
        end
    end

    assign fill_next = (fill_reg < CNT_FULL) ? fill_reg + CNT_W'(1) : fill_reg;
    assign out_load  = (state_reg == S_FLAG) && (!m_valid || m_ready);

    assign ctl.step  = out_load;
    assign ctl.raw   = max_reg > thresh_reg;
    assign ctl.last  = last_reg;
    assign ctl.clear = (state_reg == S_WRITE) && last_reg && (fill_next < win_eff);

    msd_sq_acc u_sq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .vel_x   (s_vel_x),
        .vel_y   (s_vel_y),
        .vel_z   (s_vel_z),
        .done    (sq_done),
        .norm_sq (norm_sq)
    );

    msd_ram #(.WIDTH(NORM_W), .DEPTH(MAX_WINDOW)) u_ring (
        .aclk  (aclk),
        .we    (state_reg == S_WRITE),
        .waddr (wr_ptr_reg),
        .wdata (norm_sq),
        .raddr (rd_ptr_reg),
        .rdata (ram_q)
    );

    msd_seg #(.INDEX_WIDTH(INDEX_WIDTH)) u_seg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (ctl),
        .hold_length  (hold_len_reg),
        .min_seg_len  (min_seg_reg),
        .sample_index (seg_idx),
        .moving       (seg_moving),
        .seg_valid    (seg_valid),
        .seg_start    (seg_start),
        .seg_length   (seg_len)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg   <= '0;
            window_reg   <= WIN_W'(1);
            hold_len_reg <= '0;
            min_seg_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_THRESH:  thresh_reg   <= cfg_wdata[NORM_W-1:0];
                CFG_WINDOW:  window_reg   <= cfg_wdata[WIN_W-1:0];
                CFG_HOLD:    hold_len_reg <= cfg_wdata[HOLD_W-1:0];
                CFG_MIN_SEG: min_seg_reg  <= cfg_wdata[MINSEG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            fill_reg      <= '0;
            issue_cnt_reg <= '0;
            scan_vld_reg  <= 1'b0;
            last_reg      <= 1'b0;
            m_valid       <= 1'b0;
        end else begin
            scan_vld_reg <= (state_reg == S_SCAN);
            if (scan_vld_reg && (ram_q > max_reg)) begin
                max_reg <= ram_q;
            end
            if (m_valid && m_ready && !out_load) begin
                m_valid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        last_reg  <= s_last;
                        state_reg <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (sq_done) begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    rd_ptr_reg    <= wr_ptr_reg;
                    issue_cnt_reg <= '0;
                    max_reg       <= '0;
                    if (fill_next < win_eff) begin
                        state_reg <= S_IDLE;
                        if (last_reg) begin
                            fill_reg   <= '0;
                            wr_ptr_reg <= '0;
                        end else begin
                            fill_reg   <= fill_next;
                            wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0
                                                                   : wr_ptr_reg + PTR_W'(1);
                        end
                    end else begin
                        fill_reg   <= fill_next;
                        wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
                        state_reg  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    rd_ptr_reg    <= (rd_ptr_reg == '0) ? PTR_LAST : rd_ptr_reg - PTR_W'(1);
                    issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
                    if (issue_cnt_reg == win_eff - CNT_W'(1)) begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    state_reg <= S_FLAG;
                end
                S_FLAG: begin
                    if (out_load) begin
                        m_valid          <= 1'b1;
                        m_sample_index   <= seg_idx;
                        m_moving         <= seg_moving;
                        m_segment_valid  <= seg_valid;
                        m_segment_start  <= seg_start;
                        m_segment_length <= seg_len;
                        m_final_res      <= last_reg;
                        state_reg        <= S_IDLE;
                        if (last_reg) begin
                            fill_reg   <= '0;
                            wr_ptr_reg <= '0;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input taken while busy");

    a_result_from_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_FLAG))
        else $error("result beat outside flag step");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (issue_cnt_reg < win_eff))
        else $error("ring scan past window");

    a_norm_done: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_done |-> (state_reg == S_NORM))
        else $error("norm done outside norm step");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_FULL)
        else $error("fill count overflow");
`endif

endmodule
